@@ hdl/clcd_pkg.sv @@
// Shared constants, codes and result type for the content-length deframer.
// No dependencies; imported by every module of the block, not by the interfaces.
package clcd_pkg;

  localparam int LEN_BITS_DEF = 24;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  localparam logic [3:0] KEY_LEN = 4'd14;

  // Progress through CR LF CR LF
  localparam logic [1:0] TM_NONE   = 2'd0;
  localparam logic [1:0] TM_CR     = 2'd1;
  localparam logic [1:0] TM_CRLF   = 2'd2;
  localparam logic [1:0] TM_CRLFCR = 2'd3;

  // Where the current header line stands
  localparam logic [1:0] PH_KEY    = 2'd0;
  localparam logic [1:0] PH_BLANK  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } res_t;

  // Lower-case key text, one character per position
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:    c = 8'h63; // c
        4'd1:    c = 8'h6F; // o
        4'd2:    c = 8'h6E; // n
        4'd3:    c = 8'h74; // t
        4'd4:    c = 8'h65; // e
        4'd5:    c = 8'h6E; // n
        4'd6:    c = 8'h74; // t
        4'd7:    c = 8'h2D; // -
        4'd8:    c = 8'h6C; // l
        4'd9:    c = 8'h65; // e
        4'd10:   c = 8'h6E; // n
        4'd11:   c = 8'h67; // g
        4'd12:   c = 8'h74; // t
        4'd13:   c = 8'h68; // h
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

@@ hdl/clcd_in_if.sv @@
// Input byte channel of the content-length deframer: valid/ready plus raw byte.
// Depends on nothing beyond the language.
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ hdl/clcd_out_if.sv @@
// Result channel of the content-length deframer: valid/ready plus byte, kind, last.
// Depends on nothing beyond the language.
interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

@@ hdl/clcd_parse.sv @@
// Header parser and body counter: holds all framing state, gives at most one
// result per stepped byte. Depends on clcd_pkg.
module clcd_parse #(
  parameter int LEN_BITS = clcd_pkg::LEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output clcd_pkg::res_t    res
);
  import clcd_pkg::*;

  typedef struct packed {
    logic [3:0]          kpos;
    logic                kmis;
    logic [1:0]          phase;
    logic [LEN_BITS-1:0] accum;
    logic [LEN_BITS-1:0] flen;
    logic                lerr;
  } hdr_t;

  logic                in_body, in_body_next;
  logic [1:0]          tm, tm_next;
  hdr_t                hdr, hdr_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;

  function automatic logic key_ok(input hdr_t s);
    return !s.kmis && (s.kpos == KEY_LEN);
  endfunction

  function automatic hdr_t line_char(input hdr_t s, input logic [7:0] c);
    hdr_t                r;
    logic                digit;
    logic [3:0]          d;
    logic [7:0]          lc;
    logic [LEN_BITS+3:0] v;
    begin
      r     = s;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d     = 4'(c - CH_ZERO);
      lc    = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + 8'd32 : c;
      v     = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1)
              + {{LEN_BITS{1'b0}}, d};
      case (s.phase)
        PH_KEY: begin
          if (c == CH_COLON) begin
            r.phase = PH_BLANK;
          end else if (s.kpos < KEY_LEN && lc == key_char(s.kpos)) begin
            r.kpos = s.kpos + 4'd1;
          end else begin
            r.kmis = 1'b1;
          end
        end
        PH_BLANK: begin
          if (c == CH_SPACE || c == CH_TAB) begin
            r.phase = PH_BLANK;
          end else if (digit) begin
            r.accum = {{(LEN_BITS-4){1'b0}}, d};
            r.phase = PH_DIGITS;
          end else begin
            if (key_ok(s)) r.lerr = 1'b1;
            r.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            // overflow past the length range
            if (v[LEN_BITS+3:LEN_BITS] != 4'd0) begin
              if (key_ok(s)) r.lerr = 1'b1;
              r.phase = PH_DONE;
            end else begin
              r.accum = v[LEN_BITS-1:0];
            end
          end else begin
            if (key_ok(s)) r.flen = s.accum;
            r.phase = PH_DONE;
          end
        end
        default: r = s;
      endcase
      return r;
    end
  endfunction

  function automatic hdr_t line_end(input hdr_t s);
    hdr_t r;
    begin
      r = s;
      if (key_ok(s)) begin
        if (s.phase == PH_BLANK) r.lerr = 1'b1;
        else if (s.phase == PH_DIGITS) r.flen = s.accum;
      end
      r.kpos  = '0;
      r.kmis  = 1'b0;
      r.phase = PH_KEY;
      r.accum = '0;
      return r;
    end
  endfunction

  always_comb begin
    hdr_t h;
    h               = hdr;
    hdr_next        = hdr;
    tm_next         = tm;
    in_body_next    = in_body;
    bytes_left_next = bytes_left;
    res_valid       = 1'b0;
    res             = '0;
    if (in_body) begin
      bytes_left_next = bytes_left - LEN_BITS'(1);
      res_valid       = 1'b1;
      res.out_byte    = in_byte;
      res.kind        = KIND_BODY;
      res.last        = (bytes_left == LEN_BITS'(1));
      if (bytes_left == LEN_BITS'(1)) in_body_next = 1'b0;
    end else begin
      unique case (tm)
        TM_CR, TM_CRLFCR: begin
          if (in_byte == CH_LF) begin
            h = line_end(hdr);
            if (tm == TM_CRLFCR) begin
              // end of header block: emit marker or open the body
              tm_next  = TM_NONE;
              hdr_next = '0;
              if (h.lerr) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.last  = 1'b1;
              end else if (h.flen == '0) begin
                res_valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.last  = 1'b1;
              end else begin
                in_body_next    = 1'b1;
                bytes_left_next = h.flen;
              end
            end else begin
              tm_next  = TM_CRLF;
              hdr_next = h;
            end
          end else begin
            // lone CR counts as a line byte
            h = line_char(hdr, CH_CR);
            if (in_byte == CH_CR) begin
              tm_next = TM_CR;
            end else begin
              h       = line_char(h, in_byte);
              tm_next = TM_NONE;
            end
            hdr_next = h;
          end
        end
        TM_CRLF: begin
          if (in_byte == CH_CR) begin
            tm_next = TM_CRLFCR;
          end else begin
            hdr_next = line_char(hdr, in_byte);
            tm_next  = TM_NONE;
          end
        end
        default: begin
          if (in_byte == CH_CR) begin
            tm_next = TM_CR;
          end else begin
            hdr_next = line_char(hdr, in_byte);
            tm_next  = TM_NONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body    <= 1'b0;
      tm         <= TM_NONE;
      hdr        <= '0;
      bytes_left <= '0;
    end else if (step) begin
      in_body    <= in_body_next;
      tm         <= tm_next;
      hdr        <= hdr_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

@@ hdl/content_length_deframer.sv @@
// Content-length deframer: splits a framed byte stream into body bytes and markers.
// The result of an input transfer stands in the output register in the cycle after it.
// Throughput: one byte per cycle; the next byte is taken while a result waits,
// provided the output register is free or being drained in the same cycle.
// Reset (synchronous, rst high) returns to header parsing with no length seen.
// Depends on clcd_pkg, clcd_in_if, clcd_out_if and clcd_parse.
module content_length_deframer #(
  parameter int LEN_BITS = clcd_pkg::LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  clcd_in_if.sink    in_stream,
  clcd_out_if.source out_stream
);
  import clcd_pkg::*;

  logic step;
  logic res_valid;
  res_t res;
  logic out_valid;
  res_t out_reg;

  assign in_stream.ready = !out_valid || out_stream.ready;
  assign step            = in_stream.valid && in_stream.ready;

  clcd_parse #(.LEN_BITS(LEN_BITS)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_stream.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_reg <= res;
    end
  end

  assign out_stream.valid    = out_valid;
  assign out_stream.out_byte = out_reg.out_byte;
  assign out_stream.kind     = out_reg.kind;
  assign out_stream.last     = out_reg.last;

endmodule
